/* rtl/core/ypcb_pkg.sv */
`default_nettype none

package ypcb_pkg;

   // Sequencer states, one-hot.
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCALE  = 6'b000010,
      ST_WRAP   = 6'b000100,
      ST_CORDIC = 6'b001000,
      ST_PROD   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   localparam int CNT_W   = 5;
   localparam int YAW_W   = 19;
   localparam int PITCH_W = 18;
   localparam int ANG_W   = 20;
   localparam int WRAP_W  = 29;
   localparam int MUL_W   = 17;
   localparam int PROD_W  = 34;
   localparam int XY_W    = 33;
   localparam int Z_W     = 28;
   localparam int VEC_W   = 16;
   localparam int ATAN_N  = 24;

   localparam logic [15:0] SENS_RESET = 16'd2621;

   localparam logic signed [WRAP_W-1:0] WRAP_PI   = 29'sd205888;
   localparam logic signed [WRAP_W-1:0] WRAP_2PI  = 29'sd411776;
   // Two pi shifted up by nine, larger than any scaled mouse step.
   localparam logic signed [WRAP_W-1:0] WRAP_BIAS = 29'sd210829312;
   // Counter value at which the subtract ladder reaches two pi unshifted.
   localparam logic [CNT_W-1:0] WRAP_SH0_CNT = 5'd10;

   localparam logic signed [WRAP_W-1:0] PITCH_MAX = 29'sd102288;

   localparam logic signed [ANG_W-1:0] ANG_PI      = 20'sd205888;
   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 20'sd102944;

   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

   function automatic logic signed [Z_W-1:0] atan_q24(input logic [CNT_W-1:0] idx);
      logic signed [Z_W-1:0] v;
      unique case (idx)
         5'd0:    v = 28'sd13176795;
         5'd1:    v = 28'sd7778716;
         5'd2:    v = 28'sd4110060;
         5'd3:    v = 28'sd2086331;
         5'd4:    v = 28'sd1047214;
         5'd5:    v = 28'sd524117;
         5'd6:    v = 28'sd262123;
         5'd7:    v = 28'sd131069;
         5'd8:    v = 28'sd65536;
         5'd9:    v = 28'sd32768;
         5'd10:   v = 28'sd16384;
         5'd11:   v = 28'sd8192;
         5'd12:   v = 28'sd4096;
         5'd13:   v = 28'sd2048;
         5'd14:   v = 28'sd1024;
         5'd15:   v = 28'sd512;
         5'd16:   v = 28'sd256;
         5'd17:   v = 28'sd128;
         5'd18:   v = 28'sd64;
         5'd19:   v = 28'sd32;
         5'd20:   v = 28'sd16;
         5'd21:   v = 28'sd8;
         5'd22:   v = 28'sd4;
         5'd23:   v = 28'sd2;
         default: v = 28'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [VEC_W-1:0] sat_unit(input logic signed [20:0] r);
      logic signed [VEC_W-1:0] v;
      if (r > 21'sd16384) begin
         v = 16'sd16384;
      end else if (r < -21'sd16384) begin
         v = -16'sd16384;
      end else begin
         v = r[VEC_W-1:0];
      end
      return v;
   endfunction

   // Round a Q2.28 product to Q1.14 and saturate to one.
   function automatic logic signed [VEC_W-1:0] q14(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W:0] s;
      s = (PROD_W+1)'(p) + 35'sd8192;
      return sat_unit(s[PROD_W:14]);
   endfunction

   function automatic logic signed [PITCH_W-1:0] clamp_pitch(
      input logic signed [WRAP_W-1:0] v);
      logic signed [PITCH_W-1:0] r;
      if (v > PITCH_MAX) begin
         r = PITCH_W'(PITCH_MAX);
      end else if (v < -PITCH_MAX) begin
         r = PITCH_W'(-PITCH_MAX);
      end else begin
         r = v[PITCH_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/yaw_pitch_camera_basis.sv */
`default_nettype none

// Channel   Direction  Handshake            Beat
// req_      in         req_valid/req_stall  cmd, deltas, angles to load
// rsp_      out        rsp_valid/rsp_stall  angles and forward/right/up vectors
// csr_      in         csr_valid/csr_ready  sensitivity write data
//
// The block takes one beat at a time; req_stall is high from acceptance until
// the result is written, and a direct load skips the delta scaling step.
// Two CORDIC passes run on one shared shift-add unit, next to a subtract
// ladder for the yaw wrap and one multiplier for scaling and the products.
// Synchronous reset clears both angles and loads the default sensitivity.
// A finished result sits in the output register while the next beat is taken.

module yaw_pitch_camera_basis #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire                clock,
   input  wire                reset,

   input  wire                req_valid,
   output logic               req_stall,
   input  wire                req_cmd,
   input  wire signed [15:0]  req_delta_x,
   input  wire signed [15:0]  req_delta_y,
   input  wire signed [19:0]  req_yaw_set,
   input  wire signed [19:0]  req_pitch_set,

   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic signed [18:0] rsp_yaw_now,
   output logic signed [17:0] rsp_pitch_now,
   output logic signed [15:0] rsp_fwd_x,
   output logic signed [15:0] rsp_fwd_y,
   output logic signed [15:0] rsp_fwd_z,
   output logic signed [15:0] rsp_right_x,
   output logic signed [15:0] rsp_right_z,
   output logic signed [15:0] rsp_up_x,
   output logic signed [15:0] rsp_up_y,
   output logic signed [15:0] rsp_up_z,

   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire [15:0]         csr_sensitivity
);

   import ypcb_pkg::*;

   localparam int STEPS_EFF = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;
   localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(STEPS_EFF + 1);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic sel_ff, sel_in;
   logic neg_ff, neg_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [15:0] sens_ff, sens_in;

   logic signed [15:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [YAW_W-1:0] yaw_ff, yaw_in;
   logic signed [PITCH_W-1:0] pitch_ff, pitch_in;
   logic signed [WRAP_W-1:0] wrap_ff, wrap_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in, acc_ff, acc_in;
   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0] z_ff, z_in;
   logic signed [VEC_W-1:0] cy_ff, cy_in, sy_ff, sy_in, cp_ff, cp_in, sp_ff, sp_in;
   logic signed [VEC_W-1:0] fx_ff, fx_in, fz_ff, fz_in;
   logic signed [VEC_W-1:0] upx_ff, upx_in, upy_ff, upy_in, upz_ff, upz_in;

   logic signed [YAW_W-1:0] o_yaw_ff, o_yaw_in;
   logic signed [PITCH_W-1:0] o_pitch_ff, o_pitch_in;
   logic signed [VEC_W-1:0] o_fx_ff, o_fx_in, o_fy_ff, o_fy_in, o_fz_ff, o_fz_in;
   logic signed [VEC_W-1:0] o_rx_ff, o_rx_in, o_rz_ff, o_rz_in;
   logic signed [VEC_W-1:0] o_ux_ff, o_ux_in, o_uy_ff, o_uy_in, o_uz_ff, o_uz_in;

   // Shared datapath signals.
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] scale_sum;
   logic signed [WRAP_W-1:0] scaled;
   logic [CNT_W-1:0] wrap_dist;
   logic signed [WRAP_W-1:0] wrap_step;
   logic [CNT_W-1:0] iter_idx;
   logic signed [XY_W-1:0] xs, ys;
   logic signed [ANG_W-1:0] ang_sel;
   logic signed [XY_W:0] x_rnd, y_rnd;
   logic signed [VEC_W-1:0] x_sat, y_sat, cos_v, sin_v;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // Multiplier operands follow the sequencer step.
   always_comb begin
      mul_a = MUL_W'(dx_ff);
      mul_b = MUL_W'($signed({1'b0, sens_ff}));
      if (state_ff == ST_SCALE && cnt_ff != CNT_W'(0)) begin
         mul_a = MUL_W'(dy_ff);
      end else if (state_ff == ST_PROD) begin
         unique case (cnt_ff)
            CNT_W'(0): begin mul_a = MUL_W'(cp_ff);  mul_b = MUL_W'(cy_ff); end
            CNT_W'(1): begin mul_a = MUL_W'(cp_ff);  mul_b = MUL_W'(sy_ff); end
            CNT_W'(2): begin mul_a = MUL_W'(cy_ff);  mul_b = MUL_W'(sp_ff); end
            CNT_W'(3): begin mul_a = -MUL_W'(sy_ff); mul_b = MUL_W'(sp_ff); end
            CNT_W'(4): begin mul_a = MUL_W'(cy_ff);  mul_b = MUL_W'(fx_ff); end
            CNT_W'(5): begin mul_a = MUL_W'(sy_ff);  mul_b = MUL_W'(fz_ff); end
            default:   begin mul_a = MUL_W'(cp_ff);  mul_b = MUL_W'(cy_ff); end
         endcase
      end
   end

   always_comb begin
      prod_in   = mul_a * mul_b;
      scale_sum = prod_ff + PROD_W'(8);
      scaled    = scale_sum[WRAP_W+3:4];
      wrap_dist = WRAP_SH0_CNT - cnt_ff;
      wrap_step = WRAP_2PI <<< wrap_dist[3:0];
      iter_idx  = cnt_ff - CNT_W'(1);
      xs        = x_ff >>> iter_idx;
      ys        = y_ff >>> iter_idx;
      ang_sel   = sel_ff ? ANG_W'(pitch_ff) : ANG_W'(yaw_ff);
      x_rnd     = (XY_W+1)'(x_ff) + (XY_W+1)'(32768);
      y_rnd     = (XY_W+1)'(y_ff) + (XY_W+1)'(32768);
      x_sat     = sat_unit(21'($signed(x_rnd[XY_W:16])));
      y_sat     = sat_unit(21'($signed(y_rnd[XY_W:16])));
      cos_v     = neg_ff ? -x_sat : x_sat;
      sin_v     = neg_ff ? -y_sat : y_sat;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      neg_in   = neg_ff;
      sens_in  = sens_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      yaw_in   = yaw_ff;
      pitch_in = pitch_ff;
      wrap_in  = wrap_ff;
      acc_in   = acc_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      cy_in    = cy_ff;
      sy_in    = sy_ff;
      cp_in    = cp_ff;
      sp_in    = sp_ff;
      fx_in    = fx_ff;
      fz_in    = fz_ff;
      upx_in   = upx_ff;
      upy_in   = upy_ff;
      upz_in   = upz_ff;
      o_yaw_in   = o_yaw_ff;
      o_pitch_in = o_pitch_ff;
      o_fx_in    = o_fx_ff;
      o_fy_in    = o_fy_ff;
      o_fz_in    = o_fz_ff;
      o_rx_in    = o_rx_ff;
      o_rz_in    = o_rz_ff;
      o_ux_in    = o_ux_ff;
      o_uy_in    = o_uy_ff;
      o_uz_in    = o_uz_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_valid) begin
         sens_in = csr_sensitivity;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dx_in  = req_delta_x;
               dy_in  = req_delta_y;
               cnt_in = '0;
               if (req_cmd) begin
                  wrap_in  = WRAP_W'(req_yaw_set) + WRAP_PI;
                  pitch_in = clamp_pitch(WRAP_W'(req_pitch_set));
                  state_in = ST_WRAP;
               end else begin
                  state_in = ST_SCALE;
               end
            end
         end

         ST_SCALE: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               // The product register holds the scaled horizontal delta now.
               wrap_in = WRAP_W'(yaw_ff) + WRAP_PI - scaled;
            end else if (cnt_ff == CNT_W'(2)) begin
               pitch_in = clamp_pitch(WRAP_W'(pitch_ff) + scaled);
               cnt_in   = '0;
               state_in = ST_WRAP;
            end
         end

         ST_WRAP: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(0)) begin
               // A negative sum is lifted by a multiple of two pi first.
               if (wrap_ff < 0) begin
                  wrap_in = wrap_ff + WRAP_BIAS;
               end
            end else if (cnt_ff <= WRAP_SH0_CNT) begin
               if (wrap_ff >= wrap_step) begin
                  wrap_in = wrap_ff - wrap_step;
               end
            end else begin
               yaw_in   = YAW_W'(wrap_ff - WRAP_PI);
               cnt_in   = '0;
               sel_in   = 1'b0;
               state_in = ST_CORDIC;
            end
         end

         ST_CORDIC: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(0)) begin
               // Fold the angle into the right half plane and flip the results.
               priority if (ang_sel > ANG_HALF_PI) begin
                  z_in   = Z_W'(ang_sel - ANG_PI) <<< 8;
                  neg_in = 1'b1;
               end else if (ang_sel < -ANG_HALF_PI) begin
                  z_in   = Z_W'(ang_sel + ANG_PI) <<< 8;
                  neg_in = 1'b1;
               end else begin
                  z_in   = Z_W'(ang_sel) <<< 8;
                  neg_in = 1'b0;
               end
               x_in = CORDIC_GAIN;
               y_in = '0;
            end else if (cnt_ff < CORD_LAST) begin
               if (!z_ff[Z_W-1]) begin
                  x_in = x_ff - ys;
                  y_in = y_ff + xs;
                  z_in = z_ff - atan_q24(iter_idx);
               end else begin
                  x_in = x_ff + ys;
                  y_in = y_ff - xs;
                  z_in = z_ff + atan_q24(iter_idx);
               end
            end else begin
               cnt_in = '0;
               if (!sel_ff) begin
                  cy_in  = cos_v;
                  sy_in  = sin_v;
                  sel_in = 1'b1;
               end else begin
                  cp_in    = cos_v;
                  sp_in    = sin_v;
                  state_in = ST_PROD;
               end
            end
         end

         ST_PROD: begin
            cnt_in = cnt_ff + CNT_W'(1);
            unique case (cnt_ff)
               CNT_W'(1): fx_in  = q14(prod_ff);
               CNT_W'(2): fz_in  = q14(prod_ff);
               CNT_W'(3): upx_in = q14(-prod_ff);
               CNT_W'(4): upz_in = q14(prod_ff);
               CNT_W'(5): acc_in = prod_ff;
               CNT_W'(6): begin
                  upy_in   = q14(acc_ff + prod_ff);
                  state_in = ST_DONE;
               end
               default: ;
            endcase
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               o_yaw_in     = yaw_ff;
               o_pitch_in   = pitch_ff;
               o_fx_in      = fx_ff;
               o_fy_in      = sp_ff;
               o_fz_in      = fz_ff;
               o_rx_in      = -sy_ff;
               o_rz_in      = cy_ff;
               o_ux_in      = upx_ff;
               o_uy_in      = upy_ff;
               o_uz_in      = upz_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         sel_ff       <= 1'b0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sens_ff      <= SENS_RESET;
         yaw_ff       <= '0;
         pitch_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sel_ff       <= sel_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
         sens_ff      <= sens_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      wrap_ff    <= wrap_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      cy_ff      <= cy_in;
      sy_ff      <= sy_in;
      cp_ff      <= cp_in;
      sp_ff      <= sp_in;
      fx_ff      <= fx_in;
      fz_ff      <= fz_in;
      upx_ff     <= upx_in;
      upy_ff     <= upy_in;
      upz_ff     <= upz_in;
      o_yaw_ff   <= o_yaw_in;
      o_pitch_ff <= o_pitch_in;
      o_fx_ff    <= o_fx_in;
      o_fy_ff    <= o_fy_in;
      o_fz_ff    <= o_fz_in;
      o_rx_ff    <= o_rx_in;
      o_rz_ff    <= o_rz_in;
      o_ux_ff    <= o_ux_in;
      o_uy_ff    <= o_uy_in;
      o_uz_ff    <= o_uz_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_yaw_now   = o_yaw_ff;
   assign rsp_pitch_now = o_pitch_ff;
   assign rsp_fwd_x     = o_fx_ff;
   assign rsp_fwd_y     = o_fy_ff;
   assign rsp_fwd_z     = o_fz_ff;
   assign rsp_right_x   = o_rx_ff;
   assign rsp_right_z   = o_rz_ff;
   assign rsp_up_x      = o_ux_ff;
   assign rsp_up_y      = o_uy_ff;
   assign rsp_up_z      = o_uz_ff;

endmodule

`default_nettype wire
